/* rtl/htff_pkg.sv */
// shared constants and types for the handle table with first-free allocation
package htff_pkg;

    localparam int TABLE_SLOTS_DEF = 256;
    localparam int WORD_BITS_DEF   = 32;

    localparam int ACTION_W = 2;
    localparam int ID_W     = 16;
    localparam int DATA_W   = 32;
    localparam int FREE_W   = 8;

    // widest slice of the occupancy map examined in one scan cycle
    localparam int SCAN_CHUNK_MAX = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_GET     = 2'd0,
        ACT_SET     = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_FIND    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_SCAN
    } state_t;

endpackage

/* rtl/handle_table_first_free_top.sv */
// Handle table with first-free allocation: a fixed array of slots, each holding a
// word where zero means empty. A request is accepted when start is high and busy is
// low; its single result appears for exactly one cycle with done high, and the
// receiver cannot hold it off. Get, set and release go through the registered read
// of the slot memory and then the access state, where set writes the word back and
// set and release update the occupancy map. Find-free scans the occupancy map slice
// by slice from the lowest, each slice up to 32 slots, and stops at the first slice
// holding an empty slot or after the last, at most ceil(TABLE_SLOTS / 32) slices.
// The slot memory needs no clearing after reset: the occupancy flops are cleared at
// once, and a slot marked empty reads as zero.
module handle_table_first_free_top
    import htff_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ACTION_W-1:0] action,
    input  logic [ID_W-1:0]     slot_id,
    input  logic [DATA_W-1:0]   write_word,
    output logic                done,
    output logic [DATA_W-1:0]   read_word,
    output logic [FREE_W-1:0]   free_index,
    output logic                found,
    output logic                out_of_range
);

    localparam int IDX_W      = $clog2(TABLE_SLOTS);
    localparam int CHUNK_BITS = (TABLE_SLOTS < SCAN_CHUNK_MAX) ? TABLE_SLOTS
                                                               : SCAN_CHUNK_MAX;
    localparam int NCHUNK     = (TABLE_SLOTS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int CW         = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int LW         = $clog2(CHUNK_BITS);
    localparam int FW         = CW + LW;
    localparam int PAD_BITS   = NCHUNK * CHUNK_BITS;

    localparam logic [CW-1:0] LAST_CHUNK = CW'(NCHUNK - 1);

    state_t state_reg, state_next;

    action_t              act_reg,   act_next;
    logic [IDX_W-1:0]     id_reg,    id_next;
    logic [WORD_BITS-1:0] word_reg,  word_next;
    logic                 inr_reg,   inr_next;
    logic [CW-1:0]        chunk_reg, chunk_next;
    logic [TABLE_SLOTS-1:0] occ_reg, occ_next;

    logic              done_reg,  done_next;
    logic [DATA_W-1:0] rword_reg, rword_next;
    logic [FREE_W-1:0] fidx_reg,  fidx_next;
    logic              found_reg, found_next;
    logic              oor_reg,   oor_next;

    logic                 accept;
    logic                 ram_we;
    logic                 ram_re;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [WORD_BITS+DATA_W-1:0] wext;
    logic [WORD_BITS+DATA_W-1:0] rext;
    logic [WORD_BITS-1:0]        rd_val;

    logic [PAD_BITS-1:0]   occ_pad;
    logic [CHUNK_BITS-1:0] chunk_bits;
    logic                  chunk_hit;
    logic [LW-1:0]         chunk_off;
    logic [FW-1:0]         full_idx;
    logic [FW+FREE_W-1:0]  full_ext;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // incoming word masked to the stored width
    assign wext = {{WORD_BITS{1'b0}}, write_word};

    // a slot marked empty reads as zero whatever the memory holds
    assign rd_val = occ_reg[id_reg] ? ram_rdata : '0;
    assign rext   = {{DATA_W{1'b0}}, rd_val};

    // slots beyond the table count as occupied so the scan never reports them
    always_comb
    begin
        occ_pad                    = '1;
        occ_pad[TABLE_SLOTS-1:0]   = occ_reg;
    end

    assign chunk_bits = occ_pad[chunk_reg * CHUNK_BITS +: CHUNK_BITS];

    // lowest empty slot within the current slice
    always_comb
    begin
        chunk_hit = 1'b0;
        chunk_off = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--)
        begin
            if (!chunk_bits[i])
            begin
                chunk_hit = 1'b1;
                chunk_off = LW'(i);
            end
        end
    end

    assign full_idx = (FW'(chunk_reg) << LW) | FW'(chunk_off);
    assign full_ext = {{FREE_W{1'b0}}, full_idx};

    htff_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TABLE_SLOTS),
        .AW    (IDX_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (id_reg),
        .wdata (word_reg),
        .re    (ram_re),
        .raddr (slot_id[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action_t'(action) == ACT_FIND) ? ST_SCAN : ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (chunk_hit || (chunk_reg == LAST_CHUNK))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        act_next   = act_reg;
        id_next    = id_reg;
        word_next  = word_reg;
        inr_next   = inr_reg;
        chunk_next = chunk_reg;
        occ_next   = occ_reg;
        done_next  = 1'b0;
        rword_next = rword_reg;
        fidx_next  = fidx_reg;
        found_next = found_reg;
        oor_next   = oor_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next   = action_t'(action);
                    id_next    = slot_id[IDX_W-1:0];
                    word_next  = wext[WORD_BITS-1:0];
                    inr_next   = (slot_id < ID_W'(TABLE_SLOTS));
                    chunk_next = '0;
                    ram_re     = 1'b1;
                end
            end
            ST_ACCESS:
            begin
                done_next  = 1'b1;
                fidx_next  = '0;
                found_next = 1'b0;
                oor_next   = !inr_reg;
                rword_next = '0;
                if (inr_reg)
                begin
                    if ((act_reg == ACT_GET) || (act_reg == ACT_SET))
                    begin
                        rword_next = rext[DATA_W-1:0];
                    end
                    if (act_reg == ACT_SET)
                    begin
                        ram_we           = 1'b1;
                        occ_next[id_reg] = |word_reg;
                    end
                    else if (act_reg == ACT_RELEASE)
                    begin
                        occ_next[id_reg] = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (chunk_hit || (chunk_reg == LAST_CHUNK))
                begin
                    done_next  = 1'b1;
                    rword_next = '0;
                    oor_next   = 1'b0;
                    found_next = chunk_hit;
                    fidx_next  = chunk_hit ? full_ext[FREE_W-1:0] : '0;
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chunk_reg <= '0;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        id_reg    <= id_next;
        word_reg  <= word_next;
        inr_reg   <= inr_next;
        rword_reg <= rword_next;
        fidx_reg  <= fidx_next;
        found_reg <= found_next;
        oor_reg   <= oor_next;
    end

    assign done         = done_reg;
    assign read_word    = rword_reg;
    assign free_index   = fidx_reg;
    assign found        = found_reg;
    assign out_of_range = oor_reg;

endmodule

/* rtl/htff_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module htff_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/htff_checker.sv */
// port-level checks for the handle table, bound to the top level
module htff_checker
    import htff_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic found,
    input logic out_of_range
);

    // an accepted request keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted request");

    // no result the cycle right after acceptance
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobe too early");

    // a result always closes a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside a request");

    // the result strobe of a request is never repeated back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

    // find-free never flags a range error
    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> !out_of_range)
        else $error("found and out_of_range together");

endmodule

bind handle_table_first_free_top htff_checker u_htff_checker (.*);
